FILE: src/jot_pkg.sv
`default_nettype none

package jot_pkg;

    // Fixed point format
    localparam int FRAC_BITS = 16;

    // Field widths
    localparam int IN_W  = 20;
    localparam int OUT_W = 19;
    localparam int CFG_IDX_W = 3;
    localparam int ITER_W = 4;
    localparam int MODE_W = 2;

    // Datapath widths, sized for Q3.16 inputs:
    //   first square |z^2| < 2^23 (Q16), cube term |z^3| < 2^27 (Q16)
    localparam int MUL_W  = 29;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SQ_W   = 2 * IN_W;
    localparam int SR_W   = 25;
    localparam int CU_W   = 29;
    localparam int ZW_W   = 30;
    localparam int DR_W   = IN_W + 1;
    localparam int DIST_W = 2 * DR_W;

    // floor(x/3) = (x * RECIP3) >> RECIP_SHIFT, exact for 0 <= x < 2^28
    localparam int RECIP_SHIFT = 29;
    localparam logic signed [MUL_W-1:0] RECIP3 = MUL_W'(((1 << RECIP_SHIFT) + 2) / 3);

    // Escape thresholds
    localparam logic signed [ZW_W-1:0]  TWO_Z   = ZW_W'(2 << FRAC_BITS);
    localparam logic signed [SQ_W:0]    FOUR_SQ = (SQ_W + 1)'(64'sd4 << (2 * FRAC_BITS));

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_C_REAL    = 3'd0,
        CFG_C_IMAG    = 3'd1,
        CFG_TRAP_REAL = 3'd2,
        CFG_TRAP_IMAG = 3'd3,
        CFG_MAX_ITER  = 3'd4,
        CFG_MODE      = 3'd5,
        CFG_ESC_ZERO  = 3'd6
    } t_cfg_idx;

    // Iteration functions
    localparam logic [MODE_W-1:0] MODE_SQ   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MIX  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CUBE = 2'd2;

    localparam logic [ITER_W-1:0] MAX_ITER_RST = 4'd10;

    typedef struct packed {
        logic signed [IN_W-1:0] c_real;
        logic signed [IN_W-1:0] c_imag;
        logic signed [IN_W-1:0] trap_real;
        logic signed [IN_W-1:0] trap_imag;
        logic [ITER_W-1:0]      max_iter;
        logic [MODE_W-1:0]      mode;
        logic                   esc_zero;
    } t_cfg;

endpackage

`default_nettype wire

FILE: src/jot_cfg_regs.sv
`default_nettype none

module jot_cfg_regs
    import jot_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [IN_W-1:0]      i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    // Register file; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.c_real    <= '0;
            r_cfg.c_imag    <= '0;
            r_cfg.trap_real <= '0;
            r_cfg.trap_imag <= '0;
            r_cfg.max_iter  <= MAX_ITER_RST;
            r_cfg.mode      <= MODE_SQ;
            r_cfg.esc_zero  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_C_REAL:    r_cfg.c_real    <= i_cfg_data;
                CFG_C_IMAG:    r_cfg.c_imag    <= i_cfg_data;
                CFG_TRAP_REAL: r_cfg.trap_real <= i_cfg_data;
                CFG_TRAP_IMAG: r_cfg.trap_imag <= i_cfg_data;
                CFG_MAX_ITER:  r_cfg.max_iter  <= i_cfg_data[ITER_W-1:0];
                CFG_MODE:      r_cfg.mode      <= i_cfg_data[MODE_W-1:0];
                CFG_ESC_ZERO:  r_cfg.esc_zero  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: src/jot_mul.sv
`default_nettype none

module jot_mul
    import jot_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic signed [MUL_W-1:0]  i_a,
    input  wire logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0]      o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // Shared signed multiplier, product registered
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

FILE: src/jot_core.sv
`default_nettype none

module jot_core
    import jot_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  t_cfg                          i_cfg,
    // input channel
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic signed [IN_W-1:0]   i_start_real,
    input  wire logic signed [IN_W-1:0]   i_start_imag,
    // output channel
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic signed [OUT_W-1:0]       o_point_real,
    output logic signed [OUT_W-1:0]       o_point_imag,
    output logic                          o_escaped,
    // shared multiplier
    output logic signed [MUL_W-1:0]       o_mul_a,
    output logic signed [MUL_W-1:0]       o_mul_b,
    input  wire logic signed [PROD_W-1:0] i_prod
);

    typedef enum logic [18:0] {
        S_IDLE = 19'h00001,
        S_MR   = 19'h00002,
        S_MI   = 19'h00004,
        S_MS   = 19'h00008,
        S_TD   = 19'h00010,
        S_TS   = 19'h00020,
        S_SQ   = 19'h00040,
        S_SQF  = 19'h00080,
        S_CU1  = 19'h00100,
        S_CU2  = 19'h00200,
        S_CU3  = 19'h00400,
        S_CU4  = 19'h00800,
        S_CU5  = 19'h01000,
        S_D1   = 19'h02000,
        S_D2   = 19'h04000,
        S_D3   = 19'h08000,
        S_ADD  = 19'h10000,
        S_CHK  = 19'h20000,
        S_OUT  = 19'h40000
    } t_state;

    t_state r_state, n_state;

    logic signed [IN_W-1:0]   r_zr, n_zr, r_zi, n_zi;
    logic signed [SQ_W-1:0]   r_prr, n_prr, r_pii, n_pii;
    logic signed [SR_W-1:0]   r_sr, n_sr, r_si, n_si;
    logic signed [PROD_W-1:0] r_acc, n_acc;
    logic signed [CU_W-1:0]   r_cr, n_cr, r_ci, n_ci;
    logic signed [ZW_W-1:0]   r_nr, n_nr, r_ni, n_ni;
    logic signed [OUT_W-1:0]  r_best_r, n_best_r, r_best_i, n_best_i;
    logic [DIST_W-1:0]        r_best_d, n_best_d;
    logic                     r_best_ok, n_best_ok;
    logic                     r_esc, n_esc;
    logic                     r_first, n_first;
    logic [ITER_W-1:0]        r_cnt, n_cnt;
    logic                     r_ovalid, n_ovalid;
    logic signed [OUT_W-1:0]  r_opr, n_opr, r_opi, n_opi;
    logic                     r_oesc, n_oesc;

    // Helper terms
    logic signed [DR_W-1:0]   dr, di;
    logic signed [SQ_W:0]     sq_diff, mag_sq;
    logic [DIST_W-1:0]        trap_dsq;
    logic signed [CU_W:0]     neg_cr, neg_ci;
    logic signed [MUL_W-1:0]  u_cr, u_ci;
    logic signed [CU_W-1:0]   quot;
    logic signed [ZW_W-1:0]   base_r, base_i;
    logic                     in_xfer, out_load, cube_mode, big;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign cube_mode = (i_cfg.mode == MODE_MIX) || (i_cfg.mode == MODE_CUBE);

    // Trap offsets and sums
    assign dr       = DR_W'(r_zr) - DR_W'(i_cfg.trap_real);
    assign di       = DR_W'(r_zi) - DR_W'(i_cfg.trap_imag);
    assign sq_diff  = (SQ_W + 1)'(r_prr) - (SQ_W + 1)'(r_pii);
    assign mag_sq   = (SQ_W + 1)'(r_prr) + (SQ_W + 1)'(i_prod);
    assign trap_dsq = DIST_W'(r_acc + i_prod);

    // Divide by three: operand is x or 2-x, quotient negated for negative x
    assign neg_cr = (CU_W + 1)'(2) - (CU_W + 1)'(r_cr);
    assign neg_ci = (CU_W + 1)'(2) - (CU_W + 1)'(r_ci);
    assign u_cr   = r_cr[CU_W-1] ? MUL_W'(neg_cr) : MUL_W'(r_cr);
    assign u_ci   = r_ci[CU_W-1] ? MUL_W'(neg_ci) : MUL_W'(r_ci);
    assign quot   = CU_W'(i_prod >>> RECIP_SHIFT);

    // New iterate before adding c
    always_comb begin
        if (i_cfg.mode == MODE_MIX) begin
            base_r = ZW_W'(r_sr >>> 1) + ZW_W'(r_cr);
            base_i = ZW_W'(r_si >>> 1) + ZW_W'(r_ci);
        end else if (i_cfg.mode == MODE_CUBE) begin
            base_r = ZW_W'(r_cr);
            base_i = ZW_W'(r_ci);
        end else begin
            base_r = ZW_W'(r_sr);
            base_i = ZW_W'(r_si);
        end
    end

    assign big = (r_nr > TWO_Z) || (r_nr < -TWO_Z) || (r_ni > TWO_Z) || (r_ni < -TWO_Z);

    // Output register loads when the previous result has left
    assign out_load = (r_state == S_OUT) && (!r_ovalid || i_out_ready);

    // Sequencer and operand select
    always_comb begin
        n_state   = r_state;
        n_zr      = r_zr;
        n_zi      = r_zi;
        n_prr     = r_prr;
        n_pii     = r_pii;
        n_sr      = r_sr;
        n_si      = r_si;
        n_acc     = r_acc;
        n_cr      = r_cr;
        n_ci      = r_ci;
        n_nr      = r_nr;
        n_ni      = r_ni;
        n_best_r  = r_best_r;
        n_best_i  = r_best_i;
        n_best_d  = r_best_d;
        n_best_ok = r_best_ok;
        n_esc     = r_esc;
        n_first   = r_first;
        n_cnt     = r_cnt;
        o_mul_a   = '0;
        o_mul_b   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_zr      = i_start_real;
                    n_zi      = i_start_imag;
                    n_best_r  = '0;
                    n_best_i  = '0;
                    n_best_ok = 1'b0;
                    n_esc     = 1'b0;
                    n_first   = 1'b1;
                    n_cnt     = '0;
                    n_state   = (i_cfg.max_iter == '0) ? S_OUT : S_MR;
                end
            end
            // squared components of current z
            S_MR: begin
                o_mul_a = MUL_W'(r_zr);
                o_mul_b = MUL_W'(r_zr);
                n_state = S_MI;
            end
            S_MI: begin
                o_mul_a = MUL_W'(r_zi);
                o_mul_b = MUL_W'(r_zi);
                n_prr   = SQ_W'(i_prod);
                n_state = S_MS;
            end
            // escape test on |z|^2, start trap distance; the start point skips both
            S_MS: begin
                o_mul_a = MUL_W'(dr);
                o_mul_b = MUL_W'(dr);
                n_pii   = SQ_W'(i_prod);
                if (r_first) begin
                    n_first = 1'b0;
                    n_state = S_SQ;
                end else if (mag_sq > FOUR_SQ) begin
                    n_esc   = 1'b1;
                    if (i_cfg.esc_zero) begin
                        n_best_r = '0;
                        n_best_i = '0;
                    end
                    n_state = S_OUT;
                end else begin
                    n_state = S_TD;
                end
            end
            S_TD: begin
                o_mul_a = MUL_W'(di);
                o_mul_b = MUL_W'(di);
                n_acc   = i_prod;
                n_state = S_TS;
            end
            // keep the nearest point, strictly closer only
            S_TS: begin
                if (!r_best_ok || trap_dsq < r_best_d) begin
                    n_best_ok = 1'b1;
                    n_best_d  = trap_dsq;
                    n_best_r  = OUT_W'(r_zr);
                    n_best_i  = OUT_W'(r_zi);
                end
                n_cnt   = r_cnt + 1'b1;
                n_state = (n_cnt == i_cfg.max_iter) ? S_OUT : S_SQ;
            end
            // z^2: real from cached squares, imag from zr*zi
            S_SQ: begin
                o_mul_a = MUL_W'(r_zr);
                o_mul_b = MUL_W'(r_zi);
                n_state = S_SQF;
            end
            S_SQF: begin
                n_sr    = SR_W'(sq_diff >>> FRAC_BITS);
                n_si    = SR_W'(i_prod >>> (FRAC_BITS - 1));
                n_state = cube_mode ? S_CU1 : S_ADD;
            end
            // z^3 = z^2 * z
            S_CU1: begin
                o_mul_a = MUL_W'(r_sr);
                o_mul_b = MUL_W'(r_zr);
                n_state = S_CU2;
            end
            S_CU2: begin
                o_mul_a = MUL_W'(r_si);
                o_mul_b = MUL_W'(r_zi);
                n_acc   = i_prod;
                n_state = S_CU3;
            end
            S_CU3: begin
                o_mul_a = MUL_W'(r_sr);
                o_mul_b = MUL_W'(r_zi);
                n_acc   = r_acc - i_prod;
                n_state = S_CU4;
            end
            S_CU4: begin
                o_mul_a = MUL_W'(r_si);
                o_mul_b = MUL_W'(r_zr);
                n_cr    = CU_W'(r_acc >>> FRAC_BITS);
                n_acc   = i_prod;
                n_state = S_CU5;
            end
            S_CU5: begin
                n_ci    = CU_W'((r_acc + i_prod) >>> FRAC_BITS);
                n_state = (i_cfg.mode == MODE_MIX) ? S_D1 : S_ADD;
            end
            // floor division of the cube term by three
            S_D1: begin
                o_mul_a = u_cr;
                o_mul_b = RECIP3;
                n_state = S_D2;
            end
            S_D2: begin
                o_mul_a = u_ci;
                o_mul_b = RECIP3;
                n_cr    = r_cr[CU_W-1] ? -quot : quot;
                n_state = S_D3;
            end
            S_D3: begin
                n_ci    = r_ci[CU_W-1] ? -quot : quot;
                n_state = S_ADD;
            end
            S_ADD: begin
                n_nr    = base_r + ZW_W'(i_cfg.c_real);
                n_ni    = base_i + ZW_W'(i_cfg.c_imag);
                n_state = S_CHK;
            end
            // component beyond +-2.0 escapes at once
            S_CHK: begin
                if (big) begin
                    n_esc = 1'b1;
                    if (i_cfg.esc_zero) begin
                        n_best_r = '0;
                        n_best_i = '0;
                    end
                    n_state = S_OUT;
                end else begin
                    n_zr    = IN_W'(r_nr);
                    n_zi    = IN_W'(r_ni);
                    n_state = S_MR;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        n_ovalid = r_ovalid;
        n_opr    = r_opr;
        n_opi    = r_opi;
        n_oesc   = r_oesc;
        if (out_load) begin
            n_ovalid = 1'b1;
            n_opr    = r_best_r;
            n_opi    = r_best_i;
            n_oesc   = r_esc;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zr      <= n_zr;
        r_zi      <= n_zi;
        r_prr     <= n_prr;
        r_pii     <= n_pii;
        r_sr      <= n_sr;
        r_si      <= n_si;
        r_acc     <= n_acc;
        r_cr      <= n_cr;
        r_ci      <= n_ci;
        r_nr      <= n_nr;
        r_ni      <= n_ni;
        r_best_r  <= n_best_r;
        r_best_i  <= n_best_i;
        r_best_d  <= n_best_d;
        r_best_ok <= n_best_ok;
        r_esc     <= n_esc;
        r_first   <= n_first;
        r_cnt     <= n_cnt;
        r_opr     <= n_opr;
        r_opi     <= n_opi;
        r_oesc    <= n_oesc;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_point_real = r_opr;
    assign o_point_imag = r_opi;
    assign o_escaped    = r_oesc;

endmodule

`default_nettype wire

FILE: src/julia_orbit_trap_iterator_unit.sv
`default_nettype none

// Channel  Direction  Handshake                   Payload
// in       input      i_in_valid / o_in_ready     i_start_real, i_start_imag
// out      output     o_out_valid / i_out_ready   o_point_real, o_point_imag, o_escaped
// cfg      input      i_cfg_we (no stall)         i_cfg_idx, i_cfg_data
//
// One point at a time through a single shared 29x29 multiplier. A point runs
// for max_iterations iterations, fewer on escape; z^3+c and the mixed form add
// cube steps to each iteration, and the mixed form also adds divide steps.
// Reset is synchronous, active low; it resets configuration, state and output valid.
// A finished result sits in the output register, so the next point is taken
// while it waits; only a second result waits for the output side.

module julia_orbit_trap_iterator_unit
    import jot_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [IN_W-1:0]        i_cfg_data,
    // input channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic signed [IN_W-1:0] i_start_real,
    input  wire logic signed [IN_W-1:0] i_start_imag,
    // output channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic signed [OUT_W-1:0]     o_point_real,
    output logic signed [OUT_W-1:0]     o_point_imag,
    output logic                        o_escaped
);

    t_cfg                     cfg;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    // Configuration registers
    jot_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Shared multiplier
    jot_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Sequencer, datapath and output register
    jot_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_start_real (i_start_real),
        .i_start_imag (i_start_imag),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_point_real (o_point_real),
        .o_point_imag (o_point_imag),
        .o_escaped    (o_escaped),
        .o_mul_a      (mul_a),
        .o_mul_b      (mul_b),
        .i_prod       (prod)
    );

endmodule

`default_nettype wire

FILE: test/julia_orbit_trap_iterator_unit_test.sv
`timescale 1ns / 1ps

module julia_orbit_trap_iterator_unit_test;
    import jot_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;

    localparam int LONG_HOLD  = 600;
    localparam int SETTLE_CYC = 300;
    localparam int Q_ONE      = 1 << FRAC_BITS;

    typedef struct {
        logic signed [IN_W-1:0] re;
        logic signed [IN_W-1:0] im;
    } start_pt_t;

    typedef struct {
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
        logic                    esc;
    } trap_point_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [IN_W-1:0]        i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic signed [IN_W-1:0] i_start_real = '0;
    logic signed [IN_W-1:0] i_start_imag = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic signed [OUT_W-1:0] o_point_real;
    logic signed [OUT_W-1:0] o_point_imag;
    logic                   o_escaped;

    julia_orbit_trap_iterator_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_start_real (i_start_real),
        .i_start_imag (i_start_imag),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_point_real (o_point_real),
        .o_point_imag (o_point_imag),
        .o_escaped    (o_escaped)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the configuration registers
    logic signed [IN_W-1:0] cfg_c_re = '0;
    logic signed [IN_W-1:0] cfg_c_im = '0;
    logic signed [IN_W-1:0] cfg_trap_re = '0;
    logic signed [IN_W-1:0] cfg_trap_im = '0;
    logic [ITER_W-1:0]      cfg_iter = MAX_ITER_RST;
    logic [MODE_W-1:0]      cfg_mode = MODE_SQ;
    logic                   cfg_ezero = 1'b0;

    start_pt_t   start_points_q[$];
    trap_point_t trap_points_due[$];

    bit in_taken = 1'b0;
    bit calm = 1'b0;
    int hold_asks = 0;
    int hold_served = 0;
    int fault_count = 0;

    // floor(x / 3), division in SV truncates toward zero
    function automatic longint floor_third(input longint x);
        longint q;
        q = x / 3;
        if ((x % 3) != 0 && x < 0)
            q = q - 1;
        return q;
    endfunction

    // Runs the orbit of one start point and keeps the iterate nearest the trap
    function automatic trap_point_t trace_orbit(input logic signed [IN_W-1:0] z0_re,
                                                input logic signed [IN_W-1:0] z0_im);
        longint zr, zi, sr, si, cr, ci, nr, ni, dr, di, sep_sq;
        longint best_re, best_im, best_sep;
        longint two_q, four_sq;
        bit have_best, gone;
        int k;
        trap_point_t res;
        two_q = longint'(2) << FRAC_BITS;
        four_sq = longint'(4) << (2 * FRAC_BITS);
        zr = longint'(z0_re);
        zi = longint'(z0_im);
        best_re = 0;
        best_im = 0;
        best_sep = 0;
        have_best = 1'b0;
        gone = 1'b0;
        k = 0;
        while (k < int'(cfg_iter) && !gone) begin
            sr = (zr * zr - zi * zi) >>> FRAC_BITS;
            si = (zr * zi + zi * zr) >>> FRAC_BITS;
            if (cfg_mode == MODE_MIX || cfg_mode == MODE_CUBE) begin
                cr = (sr * zr - si * zi) >>> FRAC_BITS;
                ci = (sr * zi + si * zr) >>> FRAC_BITS;
                if (cfg_mode == MODE_MIX) begin
                    nr = (sr >>> 1) + floor_third(cr);
                    ni = (si >>> 1) + floor_third(ci);
                end else begin
                    nr = cr;
                    ni = ci;
                end
            end else begin
                nr = sr;
                ni = si;
            end
            zr = nr + longint'(cfg_c_re);
            zi = ni + longint'(cfg_c_im);
            // component test first keeps the squares in range
            if (zr > two_q || zr < -two_q || zi > two_q || zi < -two_q ||
                zr * zr + zi * zi > four_sq) begin
                gone = 1'b1;
                if (cfg_ezero) begin
                    best_re = 0;
                    best_im = 0;
                end
            end else begin
                dr = zr - longint'(cfg_trap_re);
                di = zi - longint'(cfg_trap_im);
                sep_sq = dr * dr + di * di;
                if (!have_best || sep_sq < best_sep) begin
                    have_best = 1'b1;
                    best_sep = sep_sq;
                    best_re = zr;
                    best_im = zi;
                end
            end
            k++;
        end
        res.re = best_re[OUT_W-1:0];
        res.im = best_im[OUT_W-1:0];
        res.esc = gone;
        return res;
    endfunction

    task automatic report_fault(input string msg);
        if (fault_count < 10)
            $display("%0t: %s", $realtime, msg);
        fault_count++;
    endtask

    task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (got !== want)
            report_fault($sformatf("%s mismatch: expected %h, got %h", name, want, got));
    endtask

    // Sender: one start point per transfer, random gap bursts between points
    int snd_gap = 0;
    always @(negedge i_clk) begin : driver
        start_pt_t nxt;
        if (!i_in_valid || in_taken) begin
            if (snd_gap != 0) begin
                snd_gap <= snd_gap - 1;
                i_in_valid <= 1'b0;
            end else if (!calm && start_points_q.size() != 0 && $urandom_range(0, 9) == 0) begin
                snd_gap <= $urandom_range(0, 16);
                i_in_valid <= 1'b0;
            end else if (start_points_q.size() != 0) begin
                nxt = start_points_q.pop_front();
                i_in_valid <= 1'b1;
                i_start_real <= nxt.re;
                i_start_imag <= nxt.im;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts plus long holds on request
    int rcv_stall = 0;
    int hold_left = 0;
    always @(negedge i_clk) begin
        if (hold_asks != hold_served) begin
            hold_served <= hold_served + 1;
            hold_left <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (rcv_stall != 0) begin
            rcv_stall <= rcv_stall - 1;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            rcv_stall <= $urandom_range(0, 16);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Monitor: check results first, then log the prediction for a new point
    always @(posedge i_clk) begin : monitor
        trap_point_t want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                if (trap_points_due.size() == 0) begin
                    report_fault("result transfer with nothing outstanding");
                end else begin
                    want = trap_points_due.pop_front();
                    check_field("point_real", want.re, o_point_real);
                    check_field("point_imag", want.im, o_point_imag);
                    check_field("escaped", OUT_W'(want.esc), OUT_W'(o_escaped));
                end
            end
            if (i_in_valid && o_in_ready)
                trap_points_due.push_back(trace_orbit(i_start_real, i_start_imag));
        end
    end

    task automatic push_point(input logic signed [IN_W-1:0] re,
                              input logic signed [IN_W-1:0] im);
        start_pt_t p;
        p.re = re;
        p.im = im;
        start_points_q.push_back(p);
    endtask

    // Register write; write enable stays high across back-to-back writes
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [IN_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_C_REAL:    cfg_c_re = data;
            CFG_C_IMAG:    cfg_c_im = data;
            CFG_TRAP_REAL: cfg_trap_re = data;
            CFG_TRAP_IMAG: cfg_trap_im = data;
            CFG_MAX_ITER:  cfg_iter = data[ITER_W-1:0];
            CFG_MODE:      cfg_mode = data[MODE_W-1:0];
            CFG_ESC_ZERO:  cfg_ezero = data[0];
            default: ;
        endcase
    endtask

    task automatic cfg_release();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Block until every queued point is sent and every result is back
    task automatic wait_results_in();
        do begin
            @(negedge i_clk);
            #1;
        end while (start_points_q.size() != 0 || i_in_valid || trap_points_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // Mostly inside +-span, some a little past it, some over the full field
    function automatic logic signed [IN_W-1:0] pick_coord(input int span);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return IN_W'($urandom());
        if (roll == 1)
            span = span + span / 4;
        return IN_W'($urandom_range(0, 2 * span) - span);
    endfunction

    task automatic run_random_phase(input int count, input bit long_hold);
        logic [ITER_W-1:0] iter;
        iter = ($urandom_range(0, 9) == 0) ? '0 : ITER_W'($urandom_range(1, 15));
        cfg_write(CFG_C_REAL, pick_coord($urandom_range(0, 1) ? Q_ONE : 2 * Q_ONE));
        cfg_write(CFG_C_IMAG, pick_coord($urandom_range(0, 1) ? Q_ONE : 2 * Q_ONE));
        cfg_write(CFG_TRAP_REAL, pick_coord(2 * Q_ONE));
        cfg_write(CFG_TRAP_IMAG, pick_coord(2 * Q_ONE));
        cfg_write(CFG_MAX_ITER, {16'($urandom()), iter});
        cfg_write(CFG_MODE, {18'($urandom()), 2'($urandom_range(0, 3))});
        cfg_write(CFG_ESC_ZERO, {19'($urandom()), 1'($urandom_range(0, 1))});
        if ($urandom_range(0, 3) == 0)
            cfg_write(CFG_UNUSED, IN_W'($urandom()));
        cfg_release();
        if (long_hold)
            hold_asks++;
        repeat (count) push_point(pick_coord(2 * Q_ONE), pick_coord(2 * Q_ONE));
        wait_results_in();
    endtask

    // Run limit, several times the slowest legal run
    initial begin
        #5_000_000;
        $display("julia_orbit_trap_iterator_unit_test: errors");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        #1;

        // Reset configuration: c = 0, trap at origin, ten steps of z^2
        push_point(IN_W'(0), IN_W'(0));
        push_point(IN_W'(Q_ONE), IN_W'(0));
        push_point(IN_W'(78643), IN_W'(0));       // escapes on step two, keeps 1.44
        push_point(IN_W'(131073), IN_W'(0));      // just past 2.0, escapes at once
        push_point(IN_W'(-524288), IN_W'(524287));
        push_point(IN_W'(524287), IN_W'(-524288));
        wait_results_in();

        // Mixed form, long orbit, cleared on escape, unused index ignored
        cfg_write(CFG_C_REAL, IN_W'(-52429));
        cfg_write(CFG_C_IMAG, IN_W'(10224));
        cfg_write(CFG_TRAP_REAL, IN_W'(16384));
        cfg_write(CFG_TRAP_IMAG, IN_W'(-16384));
        cfg_write(CFG_MAX_ITER, IN_W'(15));
        cfg_write(CFG_MODE, IN_W'(MODE_MIX));
        cfg_write(CFG_ESC_ZERO, IN_W'(1));
        cfg_write(CFG_UNUSED, 20'hFFFFF);
        cfg_release();
        push_point(IN_W'(0), IN_W'(0));
        push_point(IN_W'(32768), IN_W'(-16384));
        push_point(IN_W'(78643), IN_W'(0));
        wait_results_in();

        // Cube with extreme constant and trap, one step
        cfg_write(CFG_C_REAL, IN_W'(524287));
        cfg_write(CFG_C_IMAG, IN_W'(-524288));
        cfg_write(CFG_TRAP_REAL, IN_W'(-524288));
        cfg_write(CFG_TRAP_IMAG, IN_W'(524287));
        cfg_write(CFG_MAX_ITER, IN_W'(1));
        cfg_write(CFG_MODE, IN_W'(MODE_CUBE));
        cfg_write(CFG_ESC_ZERO, IN_W'(0));
        cfg_release();
        push_point(IN_W'(0), IN_W'(0));
        push_point(IN_W'(1000), IN_W'(-1000));
        wait_results_in();

        // No iterations at all, spare mode code
        cfg_write(CFG_C_REAL, IN_W'(0));
        cfg_write(CFG_C_IMAG, IN_W'(0));
        cfg_write(CFG_MAX_ITER, IN_W'(0));
        cfg_write(CFG_MODE, IN_W'(MODE_SPARE));
        cfg_release();
        push_point(IN_W'(12345), IN_W'(-6789));
        push_point(IN_W'(524287), IN_W'(0));
        wait_results_in();

        // Spare mode acts as z^2 + c over a full run
        cfg_write(CFG_C_REAL, IN_W'(-40000));
        cfg_write(CFG_C_IMAG, IN_W'(30000));
        cfg_write(CFG_TRAP_REAL, IN_W'(131072));
        cfg_write(CFG_TRAP_IMAG, IN_W'(-131072));
        cfg_write(CFG_MAX_ITER, IN_W'(15));
        cfg_write(CFG_ESC_ZERO, IN_W'(1));
        cfg_release();
        push_point(IN_W'(20000), IN_W'(-30000));
        push_point(IN_W'(-131072), IN_W'(0));
        push_point(IN_W'(0), IN_W'(131072));
        wait_results_in();

        // Random phases; one with a long output hold, last one without idling
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7)
                calm = 1'b1;
            run_random_phase(50, ph == 1);
        end

        repeat (SETTLE_CYC) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("julia_orbit_trap_iterator_unit_test: clean");
        end else begin
            $display("julia_orbit_trap_iterator_unit_test: errors");
        end
        $finish;
    end

endmodule
